// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the MIDI parser RTL. Defining
// ASSERT_OFF compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/mbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Result kinds, MIDI status codes, internal record types and the radix-16
// step of the divide-by-125 used for timestamp rounding.
// ----------------------------------------------------------------------------
package mbp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_SHORT      = 2'd0;
  localparam logic [1:0] KIND_SYSEX_DATA = 2'd1;
  localparam logic [1:0] KIND_SYSEX_END  = 2'd2;

  // Full status bytes.
  localparam logic [7:0] RT_FIRST = 8'hF8;  // first real-time byte
  localparam logic [7:0] RT_UNDEF = 8'hFD;  // undefined real-time byte

  // Status high nibbles.
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_POLY_AT  = 4'hA;
  localparam logic [3:0] HI_CTRL     = 4'hB;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_CHAN_AT  = 4'hD;
  localparam logic [3:0] HI_PITCH    = 4'hE;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  // System common low nibbles.
  localparam logic [3:0] SYS_SOX      = 4'h0;
  localparam logic [3:0] SYS_MTC      = 4'h1;
  localparam logic [3:0] SYS_SONG_POS = 4'h2;
  localparam logic [3:0] SYS_SONG_SEL = 4'h3;
  localparam logic [3:0] SYS_TUNE     = 4'h6;

  // Timestamp rounding: (ns + 500) / 1000 = ((ns + 500) >> 3) / 125.
  localparam logic [63:0] ROUND_NS   = 64'd500;
  localparam int          DIV_BASE   = 125;
  localparam int          DIV_STAGES = 8;   // one numerator byte per stage
  localparam int          NUM_W      = 8 * DIV_STAGES;
  localparam int          TIME_W     = 54;

  // Up to two results caused by one input byte.
  typedef struct packed {
    logic [1:0]  res_cnt;
    logic [1:0]  kind0;
    logic [23:0] msg0;
    logic [1:0]  kind1;
    logic [23:0] msg1;
  } evt_t;

  // One queue entry: the results of a byte and their common time stamp.
  typedef struct packed {
    evt_t              evt;
    logic [TIME_W-1:0] time_us;
  } qent_t;

  typedef struct packed {
    logic [3:0] q;
    logic [6:0] r;
  } ndiv_t;

  // One radix-16 long division step by 125: remainder in, next nibble in.
  function automatic ndiv_t div125_step(input logic [6:0] rem, input logic [3:0] nib);
    logic [10:0] rp;
    logic [10:0] sub;
    logic [10:0] diff;
    ndiv_t       res;
    rp    = {rem, nib};
    sub   = '0;
    res.q = '0;
    for (int k = 1; k < 16; k++) begin
      if (rp >= 11'(k * DIV_BASE)) begin
        res.q = 4'(k);
        sub   = 11'(k * DIV_BASE);
      end
    end
    diff  = rp - sub;
    res.r = diff[6:0];
    return res;
  endfunction

endpackage

// ----- src/mbp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parser front end
// Holds the parser state and classifies each accepted byte into zero, one
// or two results.
// ----------------------------------------------------------------------------
module mbp_front import mbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       packet_start,
  output evt_t       evt
);

  logic       in_sysex, in_sysex_next;
  logic [7:0] pending_status, pending_status_next;
  logic [1:0] pending_count, pending_count_next;
  logic [1:0] pending_needed, pending_needed_next;
  logic [6:0] first_data, first_data_next;
  logic [1:0] cnt_inc;
  logic       emit;

  always_comb begin
    in_sysex_next       = in_sysex;
    pending_status_next = packet_start ? 8'h00 : pending_status;
    pending_count_next  = packet_start ? 2'd0 : pending_count;
    pending_needed_next = packet_start ? 2'd0 : pending_needed;
    first_data_next     = first_data;
    cnt_inc             = pending_count_next + 2'd1;
    emit                = 1'b0;
    evt                 = '0;

    if (data_byte >= RT_FIRST) begin
      // Real-time bytes other than 0xFD pass straight through and cancel a pending message.
      if (data_byte != RT_UNDEF) begin
        pending_needed_next = 2'd0;
        evt.res_cnt         = 2'd1;
        evt.kind0           = KIND_SHORT;
        evt.msg0            = {16'h0000, data_byte};
      end
    end else if (!data_byte[7]) begin
      if (in_sysex) begin
        evt.res_cnt = 2'd1;
        evt.kind0   = KIND_SYSEX_DATA;
        evt.msg0    = {16'h0000, data_byte};
      end else if (pending_count_next < pending_needed_next) begin
        if (pending_count_next == 2'd0) begin
          first_data_next = data_byte[6:0];
        end
        pending_count_next = cnt_inc;
        if (cnt_inc == pending_needed_next) begin
          evt.res_cnt = 2'd1;
          evt.kind0   = KIND_SHORT;
          if (pending_needed_next == 2'd2) begin
            evt.msg0 = {data_byte, 1'b0, first_data, pending_status_next};
          end else begin
            evt.msg0 = {8'h00, data_byte, pending_status_next};
          end
          pending_needed_next = 2'd0;
        end
      end
    end else begin
      // Any status byte closes an open SysEx first.
      if (in_sysex) begin
        evt.res_cnt   = 2'd1;
        evt.kind0     = KIND_SYSEX_END;
        evt.msg0      = '0;
        in_sysex_next = 1'b0;
      end
      pending_status_next = data_byte;
      pending_count_next  = 2'd0;
      pending_needed_next = 2'd0;
      unique case (data_byte[7:4]) inside
        HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_PITCH: begin
          pending_needed_next = 2'd2;
        end
        HI_PROG, HI_CHAN_AT: begin
          pending_needed_next = 2'd1;
        end
        HI_SYSTEM: begin
          unique case (data_byte[3:0]) inside
            SYS_SOX: begin
              in_sysex_next = 1'b1;
              emit          = 1'b1;
            end
            SYS_MTC, SYS_SONG_SEL: begin
              pending_needed_next = 2'd1;
            end
            SYS_SONG_POS: begin
              pending_needed_next = 2'd2;
            end
            SYS_TUNE: begin
              emit = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      if (emit) begin
        if (in_sysex) begin
          evt.res_cnt = 2'd2;
          evt.kind1   = KIND_SHORT;
          evt.msg1    = {16'h0000, data_byte};
        end else begin
          evt.res_cnt = 2'd1;
          evt.kind0   = KIND_SHORT;
          evt.msg0    = {16'h0000, data_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex       <= 1'b0;
      pending_status <= 8'h00;
      pending_count  <= 2'd0;
      pending_needed <= 2'd0;
    end else if (acc) begin
      in_sysex       <= in_sysex_next;
      pending_status <= pending_status_next;
      pending_count  <= pending_count_next;
      pending_needed <= pending_needed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      first_data <= first_data_next;
    end
  end

endmodule

// ----- src/mbp_tdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parser timestamp divider
// Pipelined rounding of nanoseconds to microseconds. The parsed results
// travel alongside; the pipeline never stalls.
// ----------------------------------------------------------------------------
module mbp_tdiv import mbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  evt_t              in_evt,
  input  logic [62:0]       timestamp_ns,
  output logic              out_valid,
  output evt_t              out_evt,
  output logic [TIME_W-1:0] time_us
);

  logic [DIV_STAGES:0] vld;
  evt_t                evt_s [DIV_STAGES+1];
  logic [NUM_W-1:0]    num_s [DIV_STAGES+1];
  logic [NUM_W-1:0]    quo_s [DIV_STAGES+1];
  logic [6:0]          rem_s [DIV_STAGES+1];
  logic [NUM_W-1:0]    quo_n [DIV_STAGES];
  logic [6:0]          rem_n [DIV_STAGES];
  logic [63:0]         sum;

  assign sum = {1'b0, timestamp_ns} + ROUND_NS;

  // Each stage retires one numerator byte as two radix-16 digits.
  always_comb begin
    ndiv_t hi;
    ndiv_t lo;
    for (int s = 0; s < DIV_STAGES; s++) begin
      hi       = div125_step(rem_s[s], num_s[s][8*(DIV_STAGES-1-s)+4 +: 4]);
      lo       = div125_step(hi.r, num_s[s][8*(DIV_STAGES-1-s) +: 4]);
      quo_n[s] = quo_s[s];
      quo_n[s][8*(DIV_STAGES-1-s) +: 8] = {hi.q, lo.q};
      rem_n[s] = lo.r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    num_s[0] <= {3'b000, sum[63:3]};
    quo_s[0] <= '0;
    rem_s[0] <= '0;
    evt_s[0] <= in_evt;
    for (int s = 0; s < DIV_STAGES; s++) begin
      num_s[s+1] <= num_s[s];
      quo_s[s+1] <= quo_n[s];
      rem_s[s+1] <= rem_n[s];
      evt_s[s+1] <= evt_s[s];
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_evt   = evt_s[DIV_STAGES];
  assign time_us   = quo_s[DIV_STAGES][TIME_W-1:0];

endmodule

// ----- src/mbp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parser result queue
// Register-based FIFO between the divider pipeline and the output stage.
// Overflow is prevented upstream by credit counting.
// ----------------------------------------------------------------------------
module mbp_queue import mbp_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  qent_t wr_data,
  input  logic  rd_en,
  output qent_t rd_data,
  output logic  rd_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  assign rd_data  = mem[rptr];
  assign rd_valid = (count != '0);

endmodule

// ----- src/mbp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parser back end
// Splits each queue entry into its one or two results and holds the
// current result in the output register.
// ----------------------------------------------------------------------------
module mbp_back import mbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qent_t             head,
  input  logic              head_valid,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        kind,
  output logic [23:0]       message,
  output logic [TIME_W-1:0] time_us,
  output logic              last
);

  logic out_valid;
  logic sub;
  logic take;
  logic split;

  // The output register reloads when it is free or being drained.
  assign take     = head_valid && (!out_valid || pop);
  assign split    = (head.evt.res_cnt == 2'd2) && !sub;
  assign head_pop = take && !split;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        sub       <= split;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      time_us <= head.time_us;
      last    <= !split;
      if (sub) begin
        kind    <= head.evt.kind1;
        message <= head.evt.msg1;
      end else begin
        kind    <= head.evt.kind0;
        message <= head.evt.msg0;
      end
    end
  end

endmodule

// ----- src/midi_byte_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Turns raw MIDI bytes into short messages, SysEx data bytes and SysEx end
// markers, each stamped with the packet time rounded to microseconds.
// ----------------------------------------------------------------------------
// Usage:
// Input channel: a byte transfers on a clock edge where push is high and
// full is low, together with packet_start and timestamp_ns.
// Result channel: while empty is low the oldest result sits on kind,
// message, time_us and last; it transfers on an edge where pop is high.
// A byte gives zero, one or two results; last marks the final one of a byte.
// Path: the first result of a byte becomes visible after these registered
// steps in order: parsing and the rounding add are captured at the transfer
// edge, the divide-by-125 pipeline follows, then the queue write and the
// load of the output register. Throughput: one byte per cycle while full is
// low; a byte with two results occupies the output register for each of its
// results in turn.
// If the receiver stalls, results collect in the queue; full rises once
// the queue plus the bytes in flight reach QUEUE_DEPTH.
// Reset (synchronous, active high) clears the parser state, the pipeline,
// the queue and the output register; no result is held afterwards.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_byte_stream_parser import mbp_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              packet_start,
  input  logic [62:0]       timestamp_ns,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        kind,
  output logic [23:0]       message,
  output logic [53:0]       time_us,
  output logic              last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          acc;
  evt_t          front_evt;
  logic          div_valid;
  evt_t          div_evt;
  logic [53:0]   div_time;
  logic          q_wr;
  logic          drop;
  qent_t         q_wdata;
  qent_t         q_head;
  logic          q_valid;
  logic          q_pop;
  logic [CW-1:0] used;

  // Every accepted byte holds a credit from transfer until its queue entry
  // is drained, or until it leaves the divider with no result at all.
  // Limiting credits to the queue depth means the queue cannot overflow.
  assign full = (used == CW'(QUEUE_DEPTH));
  assign acc  = push && !full;

  // Front end: parser state update and classification.
  mbp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .data_byte    (data_byte),
    .packet_start (packet_start),
    .evt          (front_evt)
  );

  // Time rounding pipeline; carries the parsed results alongside.
  mbp_tdiv u_tdiv (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (acc),
    .in_evt       (front_evt),
    .timestamp_ns (timestamp_ns),
    .out_valid    (div_valid),
    .out_evt      (div_evt),
    .time_us      (div_time)
  );

  // Bytes that produce nothing (dropped bytes, partial messages) never
  // enter the queue and return their credit here.
  assign q_wr            = div_valid && (div_evt.res_cnt != 2'd0);
  assign drop            = div_valid && (div_evt.res_cnt == 2'd0);
  assign q_wdata.evt     = div_evt;
  assign q_wdata.time_us = div_time;

  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wdata),
    .rd_en    (q_pop),
    .rd_data  (q_head),
    .rd_valid (q_valid)
  );

  // Back end: serializes the results of each entry into the output register.
  mbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .message    (message),
    .time_us    (time_us),
    .last       (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CW'(acc) - CW'(q_pop) - CW'(drop);
    end
  end

  // Credits never exceed the queue depth.
  `ASSERT_ALWAYS(a_credit_bound, clk, rst, used <= CW'(QUEUE_DEPTH))
  // Only a SysEx end marker can be followed by a second result of the byte.
  `ASSERT_IMPLY(a_first_is_end, clk, rst, !empty && !last, kind == KIND_SYSEX_END)
  // The second result of a byte follows its first without a gap.
  `ASSERT_NEXT(a_pair_adjacent, clk, rst, !empty && pop && !last, !empty && last)

endmodule
